/* hdl/aes128_cbc_cipher_core_defines.svh */
// Assertion macros for the AES-128 CBC cipher core checker.
// Needs clock and reset in scope where the macros are used.
`ifndef AES128_CBC_CIPHER_CORE_DEFINES_SVH
`define AES128_CBC_CIPHER_CORE_DEFINES_SVH

// checked only outside reset
`define ACBC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ACBC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/acbc_pkg.sv */
// Shared constants, types and S-box functions for the AES-128 CBC core.
// No dependencies.
package acbc_pkg;

   localparam int NumRounds = 10;

   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_KEY_HIGH = 2'd0;
   localparam reg_idx_type REG_KEY_LOW  = 2'd1;
   localparam reg_idx_type REG_IV_HIGH  = 2'd2;
   localparam reg_idx_type REG_IV_LOW   = 2'd3;

   localparam logic [7:0] GF_POLY    = 8'h1b;
   localparam logic [7:0] AFFINE_C   = 8'h63;
   localparam logic [7:0] INV_AFF_C  = 8'h05;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // inverse of the S-box affine map, without the GF inverse
   function automatic logic [7:0] inv_affine(input logic [7:0] s);
      return {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ INV_AFF_C;
   endfunction

   // S^-1(x) = A^-1(S(A^-1(x))): one table serves both directions
   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return inv_affine(SBOX[inv_affine(x)]);
   endfunction

   // next 128-bit round key from the previous one
   function automatic logic [127:0] key_next(input logic [127:0] prev, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] n0, n1, n2, n3;
      t = {sbox(prev[23:16]) ^ rc, sbox(prev[15:8]), sbox(prev[7:0]), sbox(prev[31:24])};
      n0 = prev[127:96] ^ t;
      n1 = prev[95:64] ^ n0;
      n2 = prev[63:32] ^ n1;
      n3 = prev[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

/* hdl/acbc_round.sv */
// One AES round, forward or inverse, shared by all rounds of an item.
// Depends on acbc_pkg (S-box, xtime).
module acbc_round (
   input  logic         decrypt,
   input  logic         last,
   input  logic [127:0] state_i,
   input  logic [127:0] rnd_key,
   output logic [127:0] state_o
);
   import acbc_pkg::*;

   function automatic logic [31:0] mix_col(input logic [31:0] w);
      logic [7:0] a0, a1, a2, a3, all;
      a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
      all = a0 ^ a1 ^ a2 ^ a3;
      return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
              a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
   endfunction

   // inverse mix = pre-step then forward mix
   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [7:0] u, v;
      u = xtime(xtime(w[31:24] ^ w[15:8]));
      v = xtime(xtime(w[23:16] ^ w[7:0]));
      return mix_col(w ^ {u, v, u, v});
   endfunction

   logic [127:0] sub_shift;
   logic [127:0] keyed;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            if (decrypt) begin
               sub_shift[127 - 8*(4*c + i) -: 8] =
                  inv_sbox(state_i[127 - 8*((((c - i) & 3) * 4) + i) -: 8]);
            end else begin
               sub_shift[127 - 8*(4*c + i) -: 8] =
                  sbox(state_i[127 - 8*((((c + i) & 3) * 4) + i) -: 8]);
            end
         end
      end
   end

   always_comb begin
      keyed = sub_shift ^ rnd_key;
      for (int c = 0; c < 4; c++) begin
         if (decrypt) begin
            state_o[127 - 32*c -: 32] = last ? keyed[127 - 32*c -: 32]
                                             : inv_mix_col(keyed[127 - 32*c -: 32]);
         end else begin
            state_o[127 - 32*c -: 32] = (last ? sub_shift[127 - 32*c -: 32]
                                              : mix_col(sub_shift[127 - 32*c -: 32]))
                                        ^ rnd_key[127 - 32*c -: 32];
         end
      end
   end

endmodule

/* hdl/aes128_cbc_cipher_core.sv */
// AES-128 CBC cipher core: top level with key schedule, round sequencer, CSRs.
// Depends on acbc_pkg and acbc_round.
//
// Usage:
//  - Item in on req_*: one 128-bit block (req_data_high holds bytes 0..7),
//    req_op 0 encrypts, 1 decrypts, req_restart reloads the IV as chain
//    value first. Accepted when req_valid is high and req_stall is low.
//  - Result out on rsp_*: one block per item plus rsp_last_out, a copy of
//    req_last_block. Taken when rsp_valid is high and rsp_stall is low.
//  - Key and IV are written over the APB port (64-bit registers at 8*i).
//    A key write re-runs the key schedule, with req_stall high.
//    IV writes take effect at the next restart item.
//  - Per item, the accept cycle does the first key add, then one shared
//    round unit does one round per cycle for ten rounds (the last one
//    waits for a free result register, which it loads); req_stall drops
//    the cycle after, so a new item can enter while the result waits.
//  - If the receiver stalls, the last round waits until the result
//    register is free; nothing is dropped.
//  - Reset (synchronous) clears key, IV and chain to zero and runs the
//    key schedule for the zero key before the first item.
module aes128_cbc_cipher_core #(
   parameter int NUM_ROUNDS = acbc_pkg::NumRounds
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic        req_restart,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   output logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import acbc_pkg::*;

   localparam int RW = $clog2(NUM_ROUNDS + 1);
   localparam logic [RW-1:0] LastRnd = RW'(NUM_ROUNDS);

   typedef enum logic [2:0] {
      ST_EXPAND = 3'b001,
      ST_IDLE   = 3'b010,
      ST_RUN    = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   logic [RW-1:0]  rnd_ff, rnd_in;
   logic [127:0]   rk_ff [NUM_ROUNDS + 1];
   logic [127:0]   kw_ff, kw_in;
   logic [7:0]     rcon_ff, rcon_in;
   logic [127:0]   key_ff, key_in;
   logic [127:0]   iv_ff, iv_in;
   logic [127:0]   chain_ff, chain_in;
   logic [127:0]   blk_ff, blk_in;
   logic [127:0]   din_ff, din_in;
   logic           op_ff, op_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [127:0]   rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           rk_we;
   logic [127:0]   rk_wdata;
   logic [RW-1:0]  rk_idx;
   logic [127:0]   round_out;
   logic [127:0]   chain_sel;
   logic           csr_wr;
   reg_idx_type    csr_idx;
   logic           accept;
   logic           out_free;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:3];

   always_comb begin
      case (csr_idx)
         REG_KEY_HIGH: prdata = key_ff[127:64];
         REG_KEY_LOW:  prdata = key_ff[63:0];
         REG_IV_HIGH:  prdata = iv_ff[127:64];
         REG_IV_LOW:   prdata = iv_ff[63:0];
         default:      prdata = 64'd0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // single read port on the round keys: first key at accept, then per round
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rk_idx = req_op ? LastRnd : '0;
      end else begin
         rk_idx = op_ff ? LastRnd - rnd_ff : rnd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_ff[rnd_ff] <= rk_wdata;
      end
   end

   acbc_round u_round (
      .decrypt   (op_ff),
      .last      (rnd_ff == LastRnd),
      .state_i   (blk_ff),
      .rnd_key   (rk_ff[rk_idx]),
      .state_o   (round_out)
   );

   assign chain_sel = req_restart ? iv_ff : chain_ff;

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      kw_in        = kw_ff;
      rcon_in      = rcon_ff;
      key_in       = key_ff;
      iv_in        = iv_ff;
      chain_in     = chain_ff;
      blk_in       = blk_ff;
      din_in       = din_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rk_we        = 1'b0;
      rk_wdata     = key_ff;

      case (state_ff)
         ST_EXPAND: begin
            rk_we = 1'b1;
            if (rnd_ff == '0) begin
               rk_wdata = key_ff;
               rcon_in  = RCON_FIRST;
            end else begin
               rk_wdata = key_next(kw_ff, rcon_ff);
               rcon_in  = xtime(rcon_ff);
            end
            kw_in = rk_wdata;
            if (rnd_ff == LastRnd) begin
               state_in = ST_IDLE;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               chain_in = chain_sel;
               din_in   = {req_data_high, req_data_low};
               op_in    = req_op;
               last_in  = req_last_block;
               blk_in   = {req_data_high, req_data_low} ^ rk_ff[rk_idx]
                          ^ (req_op ? 128'd0 : chain_sel);
               rnd_in   = RW'(1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rnd_ff != LastRnd) begin
               blk_in = round_out;
               rnd_in = rnd_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = op_ff ? (round_out ^ chain_ff) : round_out;
               rsp_last_in  = last_ff;
               chain_in     = op_ff ? din_ff : round_out;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_EXPAND;
            rnd_in   = '0;
         end
      endcase

      if (csr_wr) begin
         case (csr_idx)
            REG_KEY_HIGH: key_in[127:64] = pwdata;
            REG_KEY_LOW:  key_in[63:0]   = pwdata;
            REG_IV_HIGH:  iv_in[127:64]  = pwdata;
            REG_IV_LOW:   iv_in[63:0]    = pwdata;
            default: ;
         endcase
         if (csr_idx == REG_KEY_HIGH || csr_idx == REG_KEY_LOW) begin
            state_in = ST_EXPAND;
            rnd_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXPAND;
         rnd_ff       <= '0;
         key_ff       <= '0;
         iv_ff        <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         key_ff       <= key_in;
         iv_ff        <= iv_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kw_ff       <= kw_in;
      rcon_ff     <= rcon_in;
      blk_ff      <= blk_in;
      din_ff      <= din_in;
      op_ff       <= op_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_data_ff[127:64];
   assign rsp_result_low  = rsp_data_ff[63:0];
   assign rsp_last_out    = rsp_last_ff;

endmodule

/* hdl/acbc_checker.sv */
// Port-level checks for the AES-128 CBC core, bound to the top level.
// Depends on aes128_cbc_cipher_core_defines.svh.
`include "aes128_cbc_cipher_core_defines.svh"

module acbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_high,
   input logic [63:0] rsp_result_low,
   input logic        rsp_last_out,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [4:0]  paddr
);

   // key schedule runs after reset before any item enters
   `ACBC_ASSERT_ALWAYS(a_stall_after_reset, $past(reset) |-> req_stall, "no stall after reset")

   // one item at a time: an accepted item blocks the input
   `ACBC_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "input open while busy")

   // a key write restarts the key schedule
   `ACBC_ASSERT(a_stall_after_key, (psel && penable && pwrite && !paddr[4]) |=> req_stall, "no stall after key write")

   // a stalled result holds
   `ACBC_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_high) && $stable(rsp_result_low) && $stable(rsp_last_out)), "stalled result changed")

endmodule

bind aes128_cbc_cipher_core acbc_checker u_acbc_checker (.*);

/* tb/sv/aes128_cbc_cipher_core_test.sv */
// Testbench for the AES-128 CBC cipher core: random and directed blocks, checked
// against an in-bench AES-128 CBC predictor. Depends on acbc_pkg and the core.
`timescale 1ns / 1ps

module aes128_cbc_cipher_core_test;
   import acbc_pkg::*;

   typedef struct packed {
      logic        op;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic        restart;
      logic        last_block;
   } block_item_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
      logic        last_out;
   } block_result_type;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = 1'b0;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low = '0;
   logic        req_restart = 1'b0;
   logic        req_last_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        rsp_last_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   aes128_cbc_cipher_core i_dut (.*);

   initial forever #2 clock = ~clock;

   // predictor state
   logic [127:0] key_reg, iv_reg, chain_val;
   logic [127:0] sched [0:10];
   logic [7:0]   inv_tab [256];

   block_item_type   pending_blocks [$];
   block_result_type expected_blocks [$];
   int  mismatches = 0;
   bit  long_hold = 0;
   bit  long_hold_done = 0;
   int  hold_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;

   function automatic logic [7:0] dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = dbl(a);
      end
      return r;
   endfunction

   // byte n of a block, byte 0 in the top bits
   function automatic logic [7:0] byte_of(logic [127:0] s, int n);
      return s[127 - 8 * n -: 8];
   endfunction

   function automatic void expand_schedule();
      logic [31:0] w [0:43];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32 * i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
            rc = dbl(rc);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r <= 10; r++) sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
   endfunction

   function automatic logic [127:0] encipher(logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, al;
      s ^= sched[0];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[127 - 8 * (4 * c + i) -: 8] = SBOX[byte_of(s, ((c + i) % 4) * 4 + i)];
         s = t;
         if (r != 10)
            for (int c = 0; c < 4; c++) begin
               a0 = byte_of(s, 4 * c); a1 = byte_of(s, 4 * c + 1);
               a2 = byte_of(s, 4 * c + 2); a3 = byte_of(s, 4 * c + 3);
               al = a0 ^ a1 ^ a2 ^ a3;
               s[127 - 32 * c -: 32] = {a0 ^ al ^ dbl(a0 ^ a1), a1 ^ al ^ dbl(a1 ^ a2),
                                       a2 ^ al ^ dbl(a2 ^ a3), a3 ^ al ^ dbl(a3 ^ a0)};
            end
         s ^= sched[r];
      end
      return s;
   endfunction

   function automatic logic [127:0] decipher(logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a, b, c2, d;
      s ^= sched[10];
      for (int r = 9; r >= 0; r--) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[127 - 8 * (((c + i) % 4) * 4 + i) -: 8] = inv_tab[byte_of(s, 4 * c + i)];
         s = t ^ sched[r];
         if (r != 0)
            for (int c = 0; c < 4; c++) begin
               a = byte_of(s, 4 * c); b = byte_of(s, 4 * c + 1);
               c2 = byte_of(s, 4 * c + 2); d = byte_of(s, 4 * c + 3);
               s[127 - 32 * c -: 32] = {
                  gmul(a, 8'h0e) ^ gmul(b, 8'h0b) ^ gmul(c2, 8'h0d) ^ gmul(d, 8'h09),
                  gmul(a, 8'h09) ^ gmul(b, 8'h0e) ^ gmul(c2, 8'h0b) ^ gmul(d, 8'h0d),
                  gmul(a, 8'h0d) ^ gmul(b, 8'h09) ^ gmul(c2, 8'h0e) ^ gmul(d, 8'h0b),
                  gmul(a, 8'h0b) ^ gmul(b, 8'h0d) ^ gmul(c2, 8'h09) ^ gmul(d, 8'h0e)};
            end
      end
      return s;
   endfunction

   function automatic block_result_type cbc_predict(block_item_type it);
      block_result_type res;
      logic [127:0] blk, out;
      blk = {it.data_high, it.data_low};
      if (it.restart) chain_val = iv_reg;
      if (it.op == OP_ENCRYPT) begin
         out = encipher(blk ^ chain_val);
         chain_val = out;
      end else begin
         out = decipher(blk) ^ chain_val;
         chain_val = blk;
      end
      res.result_high = out[127:64];
      res.result_low = out[63:0];
      res.last_out = it.last_block;
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         default: ;
      endcase
      return v;
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_blocks.size() != 0) begin
            block_item_type it;
            it = pending_blocks.pop_front();
            expected_blocks.push_back(cbc_predict(it));
            req_valid <= 1'b1;
            req_op <= it.op;
            req_data_high <= it.data_high;
            req_data_low <= it.data_low;
            req_restart <= it.restart;
            req_last_block <= it.last_block;
            gap_left <= rand_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off when asked
   always @(posedge clock) begin
      if (long_hold && !long_hold_done) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == 200) long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= rand_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h", rsp_result_high, rsp_result_low);
         end else begin
            block_result_type e;
            e = expected_blocks.pop_front();
            if (e.result_high !== rsp_result_high || e.result_low !== rsp_result_low
                || e.last_out !== rsp_last_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %b, got %h %h %b",
                           e.result_high, e.result_low, e.last_out,
                           rsp_result_high, rsp_result_low, rsp_last_out);
            end
         end
      end
   end

   task automatic csr_write(reg_idx_type idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_KEY_HIGH: begin key_reg[127:64] = value; expand_schedule(); end
         REG_KEY_LOW:  begin key_reg[63:0] = value; expand_schedule(); end
         REG_IV_HIGH:  iv_reg[127:64] = value;
         REG_IV_LOW:   iv_reg[63:0] = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_blocks.size() != 0 || expected_blocks.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic queue_block(logic op, logic [63:0] hi, logic [63:0] lo, logic rs, logic lb);
      block_item_type it;
      it = '{op, hi, lo, rs, lb};
      pending_blocks.push_back(it);
   endtask

   // random messages: mostly encrypt or decrypt runs starting with a restart
   task automatic queue_messages(int n);
      int len;
      logic op;
      while (n > 0) begin
         len = $urandom_range(1, 8);
         op = 1'($urandom_range(0, 1));
         for (int i = 0; i < len && n > 0; i++, n--) begin
            if ($urandom_range(0, 9) == 0) op = ~op;
            queue_block(op, rand64(), rand64(), i == 0 || $urandom_range(0, 15) == 0,
                        i == len - 1 ? 1'b1 : 1'(($urandom_range(0, 15) == 0)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) inv_tab[SBOX[i]] = i[7:0];
      key_reg = '0; iv_reg = '0; chain_val = '0;
      expand_schedule();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero key and IV straight after reset
      queue_block(OP_ENCRYPT, '0, '0, 1'b0, 1'b0);
      queue_block(OP_DECRYPT, '1, '1, 1'b0, 1'b1);
      drain();

      // FIPS-197 example key, then all-ones, chaining through restarts
      csr_write(REG_KEY_HIGH, 64'h0001020304050607);
      csr_write(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      csr_write(REG_IV_HIGH, '0);
      csr_write(REG_IV_LOW, '0);
      queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
      queue_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, 1'b1);
      queue_block(OP_ENCRYPT, '1, '1, 1'b0, 1'b0);
      queue_block(OP_ENCRYPT, '0, '0, 1'b0, 1'b1);
      queue_block(OP_DECRYPT, 64'h8000000000000000, 64'h1, 1'b0, 1'b0);
      queue_block(OP_DECRYPT, '0, '0, 1'b1, 1'b1);
      drain();

      // new IV without a restart keeps the old chain
      csr_write(REG_IV_HIGH, '1);
      csr_write(REG_IV_LOW, '1);
      queue_block(OP_ENCRYPT, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0, 1'b0);
      queue_block(OP_ENCRYPT, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b1, 1'b1);
      queue_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0);
      drain();
      csr_write(REG_KEY_HIGH, '1);
      csr_write(REG_KEY_LOW, '1);
      queue_block(OP_ENCRYPT, '1, '0, 1'b1, 1'b1);
      queue_block(OP_DECRYPT, '0, '1, 1'b0, 1'b0);
      drain();

      // long receiver hold-off while the sender keeps offering items
      long_hold = 1;
      queue_messages(40);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         csr_write(REG_KEY_HIGH, rand64());
         csr_write(REG_KEY_LOW, rand64());
         csr_write(REG_IV_HIGH, rand64());
         csr_write(REG_IV_LOW, rand64());
         queue_messages(240);
         drain();
      end

      if (mismatches == 0) $display("PASS aes128_cbc_cipher_core");
      else $display("FAIL aes128_cbc_cipher_core");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL aes128_cbc_cipher_core");
      $finish;
   end

endmodule
